// File: hw/rtl/rbfw_pkg.sv
// shared types and constants for the rbf warp point evaluator
package rbfw_pkg;

	localparam int SQ_STEPS = 31;  // result bits of the kernel square root
	localparam int SQ_W     = 63;  // width of the square root operand
	localparam int TERM_W   = 50;  // width of one basis term after the q16.16 shift
	localparam int ACC_W    = 64;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [2:0] {
		REG_POINT_COUNT = 3'd0,
		REG_AFFINE_M00  = 3'd1,
		REG_AFFINE_M01  = 3'd2,
		REG_AFFINE_M10  = 3'd3,
		REG_AFFINE_M11  = 3'd4,
		REG_OFFSET_X    = 3'd5,
		REG_OFFSET_Y    = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AFF,
		ST_ISSUE,
		ST_DRAIN,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic               kind;
		logic [5:0]         slot;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [31:0] coef_x;
		logic signed [31:0] coef_y;
		logic [31:0]        radius;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] warped_x;
		logic signed [15:0] warped_y;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [31:0] coef_x;
		logic signed [31:0] coef_y;
		logic [31:0]        radius;
	} entry_t;

	typedef struct packed {
		logic               valid;
		logic signed [15:0] px;
		logic signed [15:0] py;
		entry_t             entry;
	} term_in_t;

	typedef struct packed {
		logic                     valid;
		logic signed [TERM_W-1:0] x;
		logic signed [TERM_W-1:0] y;
	} term_out_t;

endpackage

// File: hw/rtl/rbfw_sqrt.sv
// pipelined integer square root, one result bit per stage, with a tag carried alongside
module rbfw_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [rbfw_pkg::SQ_W-1:0]     in_val,
	input  logic [63:0]                   in_tag,
	output logic                          out_valid,
	output logic [rbfw_pkg::SQ_STEPS-1:0] out_root,
	output logic [63:0]                   out_tag,
	output logic                          busy
);
	import rbfw_pkg::*;

	logic [SQ_STEPS-1:0] v_s;
	logic [SQ_W-1:0]     rem_s  [SQ_STEPS];
	logic [SQ_STEPS-1:0] root_s [SQ_STEPS];
	logic [63:0]         tag_s  [SQ_STEPS];

	logic [SQ_STEPS-1:0] v_i;
	logic [SQ_W-1:0]     rem_i  [SQ_STEPS];
	logic [SQ_STEPS-1:0] root_i [SQ_STEPS];
	logic [63:0]         tag_i  [SQ_STEPS];
	logic [SQ_W-1:0]     trial  [SQ_STEPS];

	always_comb begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			if (k == 0) begin
				v_i[k]    = in_valid;
				rem_i[k]  = in_val;
				root_i[k] = '0;
				tag_i[k]  = in_tag;
			end else begin
				v_i[k]    = v_s[k-1];
				rem_i[k]  = rem_s[k-1];
				root_i[k] = root_s[k-1];
				tag_i[k]  = tag_s[k-1];
			end
			// (root + 2^j)^2 - root^2
			trial[k] = (SQ_W'(root_i[k]) << (SQ_STEPS - k))
				+ (SQ_W'(1) << (2 * (SQ_STEPS - 1 - k)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			tag_s[k] <= tag_i[k];
			if (rem_i[k] >= trial[k]) begin
				rem_s[k]  <= rem_i[k] - trial[k];
				root_s[k] <= root_i[k] | (SQ_STEPS'(1) << (SQ_STEPS - 1 - k));
			end else begin
				rem_s[k]  <= rem_i[k];
				root_s[k] <= root_i[k];
			end
		end
	end

	assign out_valid = v_s[SQ_STEPS-1];
	assign out_root  = root_s[SQ_STEPS-1];
	assign out_tag   = tag_s[SQ_STEPS-1];
	assign busy      = |v_s;

endmodule

// File: hw/rtl/rbfw_term.sv
// basis term pipeline: distance, multiquadric kernel and coefficient product per point
module rbfw_term (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rbfw_pkg::term_in_t   req,
	output rbfw_pkg::term_out_t  rsp,
	output logic                 busy
);
	import rbfw_pkg::*;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [16:0] dx_s1, dy_s1;
	logic [31:0]        r_s1;
	logic signed [31:0] cx_s1, cy_s1, cx_s2, cy_s2, cx_s3, cy_s3;
	logic [32:0]        dx2_s2, dy2_s2;
	logic [63:0]        r2_s2;
	logic [SQ_W-1:0]    s_s3;
	logic signed [63:0] px_s4, py_s4;

	logic signed [33:0]  sqx, sqy;
	logic [63:0]         r2;
	logic [33:0]         dsum;
	logic                sq_valid, sq_busy;
	logic [SQ_STEPS-1:0] sq_root;
	logic [63:0]         sq_tag;
	logic signed [31:0]  h_signed;

	assign sqx  = dx_s1 * dx_s1;
	assign sqy  = dy_s1 * dy_s1;
	assign r2   = r_s1 * r_s1;
	assign dsum = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= 17'(req.px) - 17'(req.entry.pos_x);
		dy_s1  <= 17'(req.py) - 17'(req.entry.pos_y);
		r_s1   <= req.entry.radius;
		cx_s1  <= req.entry.coef_x;
		cy_s1  <= req.entry.coef_y;
		dx2_s2 <= sqx[32:0];
		dy2_s2 <= sqy[32:0];
		r2_s2  <= r2;
		cx_s2  <= cx_s1;
		cy_s2  <= cy_s1;
		// distance squared in q35.28 plus radius squared cut to the same scale
		s_s3   <= SQ_W'({dsum, 28'b0}) + SQ_W'(r2_s2[63:4]);
		cx_s3  <= cx_s2;
		cy_s3  <= cy_s2;
		px_s4  <= $signed(sq_tag[31:0]) * h_signed;
		py_s4  <= $signed(sq_tag[63:32]) * h_signed;
	end

	rbfw_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_val    (s_s3),
		.in_tag    ({cy_s3, cx_s3}),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_tag   (sq_tag),
		.busy      (sq_busy)
	);

	assign h_signed = $signed({1'b0, sq_root});

	// arithmetic shift by 14 rounds toward minus infinity
	always_comb begin
		rsp.valid = v_s4;
		rsp.x     = px_s4[63:14];
		rsp.y     = py_s4[63:14];
	end

	assign busy = v_s1 | v_s2 | v_s3 | sq_busy | v_s4;

endmodule

// File: hw/rtl/rbf_warp_point_evaluator_unit.sv
// top level: control point table, affine part, term accumulation and result register
//
// Load transactions write one control point entry. A query transaction steps through n table
// entries, n being point_count capped at MAX_POINTS: the table is read one entry per cycle
// into the term pipeline (distance, 31-stage square root, coefficient multiply), and the
// sums are then drained and truncated toward zero to whole pixels. One transaction is
// worked on at a time; req_stall is high meanwhile. A finished result waits in the output
// register, so the next transaction can be taken before it is collected. The table has no
// reset; entries must be written before a query reads them, and the block itself does
// not enforce this.
module rbf_warp_point_evaluator_unit #(
	parameter int MAX_POINTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  rbfw_pkg::in_item_t  req_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rbfw_pkg::out_item_t rsp_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import rbfw_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [6:0]         point_count_q;
	logic signed [31:0] m00_q, m01_q, m10_q, m11_q, off_x_q, off_y_q;

	st_t state_q, state_d;
	logic [CW-1:0] idx_q, n_q;
	logic signed [15:0] pq_x_q, pq_y_q;
	logic signed [47:0] aff_xa_q, aff_xb_q, aff_ya_q, aff_yb_q;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q;
	logic rsp_valid_q;
	out_item_t rsp_q;

	entry_t mem [MAX_POINTS];
	entry_t rd_s1;
	logic   rd_v_s1;

	logic req_acc, rd_en, acc_init, out_load;
	term_in_t  term_req;
	term_out_t term_rsp;
	logic      term_busy;

	function automatic logic signed [15:0] to_pixel(input logic signed [ACC_W-1:0] q);
		logic signed [ACC_W-1:0] biased;
		logic signed [ACC_W-17:0] p;
		biased = q + ((q < 0) ? ACC_W'(65535) : ACC_W'(0));
		p = biased[ACC_W-1:16];
		if (p > 32767) begin
			return 16'sh7fff;
		end else if (p < -32768) begin
			return 16'sh8000;
		end
		return p[15:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign req_acc   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			m00_q   <= 32'sd65536;
			m01_q   <= '0;
			m10_q   <= '0;
			m11_q   <= 32'sd65536;
			off_x_q <= '0;
			off_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POINT_COUNT: point_count_q <= cfg_data[6:0];
				REG_AFFINE_M00:  m00_q   <= cfg_data;
				REG_AFFINE_M01:  m01_q   <= cfg_data;
				REG_AFFINE_M10:  m10_q   <= cfg_data;
				REG_AFFINE_M11:  m11_q   <= cfg_data;
				REG_OFFSET_X:    off_x_q <= cfg_data;
				REG_OFFSET_Y:    off_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		rd_en     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid && req_data.kind == KIND_QUERY) state_d = ST_AFF;
			end
			ST_AFF: state_d = ST_ISSUE;
			ST_ISSUE: begin
				if (idx_q == n_q) state_d = ST_DRAIN;
				else rd_en = 1'b1;
			end
			ST_DRAIN: begin
				if (!rd_v_s1 && !term_busy) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign acc_init = (state_q == ST_ISSUE) && (idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			n_q     <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			if (req_acc) begin
				idx_q <= '0;
				n_q   <= (32'(point_count_q) > MAX_POINTS) ? CW'(MAX_POINTS)
					: CW'(point_count_q);
			end else if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// control point table
	always_ff @(posedge clk) begin
		if (req_acc && req_data.kind == KIND_LOAD && 32'(req_data.slot) < MAX_POINTS) begin
			mem[AW'(req_data.slot)] <= '{pos_x: req_data.pos_x, pos_y: req_data.pos_y,
				coef_x: req_data.coef_x, coef_y: req_data.coef_y,
				radius: req_data.radius};
		end
		if (rd_en) begin
			rd_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			pq_x_q <= req_data.pos_x;
			pq_y_q <= req_data.pos_y;
		end
		aff_xa_q <= m00_q * pq_x_q;
		aff_xb_q <= m01_q * pq_y_q;
		aff_ya_q <= m10_q * pq_x_q;
		aff_yb_q <= m11_q * pq_y_q;
		if (acc_init) begin
			acc_x_q <= ACC_W'(off_x_q) + ACC_W'(aff_xa_q) + ACC_W'(aff_xb_q);
			acc_y_q <= ACC_W'(off_y_q) + ACC_W'(aff_ya_q) + ACC_W'(aff_yb_q);
		end else if (term_rsp.valid) begin
			acc_x_q <= acc_x_q + ACC_W'(term_rsp.x);
			acc_y_q <= acc_y_q + ACC_W'(term_rsp.y);
		end
	end

	always_comb begin
		term_req.valid = rd_v_s1;
		term_req.px    = pq_x_q;
		term_req.py    = pq_y_q;
		term_req.entry = rd_s1;
	end

	rbfw_term u_term (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (term_req),
		.rsp    (term_rsp),
		.busy   (term_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q.warped_x <= to_pixel(acc_x_q);
			rsp_q.warped_y <= to_pixel(acc_y_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// a result only appears out of the output state
	a_rsp_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");

	// every term has reached the accumulator before the result is formed
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (!term_busy && !rd_v_s1))
		else $error("result formed while terms in flight");

	// table reads are issued only while stepping through the points
	a_read_issue: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> $past(state_q == ST_ISSUE))
		else $error("table read outside issue state");

endmodule

// File: bench/rbf_warp_point_evaluator_unit_tb.sv
// testbench for the rbf warp point evaluator: random loads, queries and register settings
module rbf_warp_point_evaluator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rbfw_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int TABLE_DEPTH = 64;

	// expected warp results and the block's mirrored table and registers
	class warp_scoreboard;
		logic [6:0]         point_count;
		logic signed [31:0] m00, m01, m10, m11, off_x, off_y;
		entry_t             points [TABLE_DEPTH];
		out_item_t          pending_warps [$];
		int                 mismatches;
		int                 matched;
		int                 loads;
		int                 queries;

		function new();
			point_count = '0;
			m00 = 32'sd65536;
			m01 = '0;
			m10 = '0;
			m11 = 32'sd65536;
			off_x = '0;
			off_y = '0;
			mismatches = 0;
			matched = 0;
			loads = 0;
			queries = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_POINT_COUNT: point_count = v[6:0];
				REG_AFFINE_M00: m00 = v;
				REG_AFFINE_M01: m01 = v;
				REG_AFFINE_M10: m10 = v;
				REG_AFFINE_M11: m11 = v;
				REG_OFFSET_X: off_x = v;
				REG_OFFSET_Y: off_y = v;
				default: ;
			endcase
		endfunction

		function bit [63:0] kernel_sqrt(bit [63:0] v);
			bit [63:0] res;
			bit [63:0] b;
			res = '0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function logic signed [15:0] to_pixel(longint q);
			longint p;
			p = q / 65536;
			if (p > 32767)
				p = 32767;
			if (p < -32768)
				p = -32768;
			return p[15:0];
		endfunction

		function out_item_t warp(in_item_t it);
			longint    ax, ay, dx, dy, h, cx, cy;
			bit [63:0] s, r;
			int        n;
			out_item_t res;
			ax = longint'(m00) * it.pos_x + longint'(m01) * it.pos_y + longint'(off_x);
			ay = longint'(m10) * it.pos_x + longint'(m11) * it.pos_y + longint'(off_y);
			n = (point_count > TABLE_DEPTH) ? TABLE_DEPTH : point_count;
			for (int i = 0; i < n; i++) begin
				dx = longint'(it.pos_x) - longint'(points[i].pos_x);
				dy = longint'(it.pos_y) - longint'(points[i].pos_y);
				r = {32'd0, points[i].radius};
				s = (64'(dx * dx + dy * dy) << 28) + ((r * r) >> 4);
				h = longint'(kernel_sqrt(s));
				cx = longint'(points[i].coef_x);
				cy = longint'(points[i].coef_y);
				// arithmetic shift floors toward minus infinity
				ax += (cx * h) >>> 14;
				ay += (cy * h) >>> 14;
			end
			res.warped_x = to_pixel(ax);
			res.warped_y = to_pixel(ay);
			return res;
		endfunction

		function void note_input(in_item_t it);
			if (it.kind == KIND_LOAD) begin
				points[it.slot].pos_x = it.pos_x;
				points[it.slot].pos_y = it.pos_y;
				points[it.slot].coef_x = it.coef_x;
				points[it.slot].coef_y = it.coef_y;
				points[it.slot].radius = it.radius;
				loads++;
			end else begin
				pending_warps = {pending_warps, warp(it)};
				queries++;
			end
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: %s", $time, msg);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_warps.size() == 0) begin
				report($sformatf("unexpected result x=%0d y=%0d", got.warped_x, got.warped_y));
				return;
			end
			want = pending_warps.pop_front();
			if (got.warped_x !== want.warped_x || got.warped_y !== want.warped_y)
				report($sformatf("expected x=%0d y=%0d, got x=%0d y=%0d",
					want.warped_x, want.warped_y, got.warped_x, got.warped_y));
			else
				matched++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	in_item_t    req_data;
	logic        rsp_valid;
	logic        rsp_stall;
	out_item_t   rsp_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	warp_scoreboard sb;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_off;
	int          cfg_writes;

	rbf_warp_point_evaluator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// receiver: random stall, long hold-off on request, checks each result transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				sb.check_result(rsp_data);
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	function logic [31:0] pick32();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			4, 5: return 32'($signed($urandom_range(262144)) - 131072);
			default: return $urandom();
		endcase
	endfunction

	function logic [15:0] pick16();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(2000)) - 1000);
			default: return 16'($urandom());
		endcase
	endfunction

	function in_item_t make_load(logic [5:0] slot);
		in_item_t it;
		it.kind = KIND_LOAD;
		it.slot = slot;
		it.pos_x = pick16();
		it.pos_y = pick16();
		it.coef_x = pick32();
		it.coef_y = pick32();
		it.radius = $urandom_range(1) ? $urandom() : pick32();
		return it;
	endfunction

	function in_item_t make_query(logic signed [15:0] x, logic signed [15:0] y);
		in_item_t it;
		it = make_load(6'($urandom()));
		it.kind = KIND_QUERY;
		it.pos_x = x;
		it.pos_y = y;
		return it;
	endfunction

	task automatic send(in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= it;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_input(it);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_reg(idx, v);
		cfg_writes++;
	endtask

	// a load leaves no trace in the queue, so wait out one full query latency too
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (sb.pending_warps.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic random_settings(bit wide);
		logic [6:0] n;
		n = wide ? 7'($urandom_range(64, 127)) : 7'($urandom_range(0, 8));
		write_reg(REG_POINT_COUNT, {25'd0, n});
		// mostly near-identity affine so warped pixels stay inside range
		write_reg(REG_AFFINE_M00, $urandom_range(3) ? 32'($urandom_range(131072)) : pick32());
		write_reg(REG_AFFINE_M01, $urandom_range(3) ? 32'(int'($urandom_range(32768)) - 16384)
			: pick32());
		write_reg(REG_AFFINE_M10, $urandom_range(3) ? 32'(int'($urandom_range(32768)) - 16384)
			: pick32());
		write_reg(REG_AFFINE_M11, $urandom_range(3) ? 32'($urandom_range(131072)) : pick32());
		write_reg(REG_OFFSET_X, pick32());
		write_reg(REG_OFFSET_Y, pick32());
		cfg_valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 12;
		recv_idle_pct = 88;
		hold_off = 0;
		cfg_writes = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, no points, extreme pixels
		send(make_query(16'sh7fff, 16'sh8000));
		send(make_query(16'sh8000, 16'sh7fff));
		send(make_query(16'sh0000, 16'shffff));
		// extreme control points in the first slots
		begin
			in_item_t it;
			it = make_load(6'd0);
			it.pos_x = 16'sh8000;
			it.pos_y = 16'sh8000;
			it.coef_x = 32'sh7fff_ffff;
			it.coef_y = 32'sh8000_0000;
			it.radius = 32'hffff_ffff;
			send(it);
			it = make_load(6'd1);
			it.pos_x = 16'sh7fff;
			it.pos_y = 16'sh7fff;
			it.coef_x = 32'sh8000_0000;
			it.coef_y = 32'sh7fff_ffff;
			it.radius = 32'h0;
			send(it);
			it = make_load(6'd2);
			it.pos_x = 16'sd0;
			it.pos_y = 16'sd0;
			it.coef_x = 32'sd65536;
			it.coef_y = -32'sd65536;
			it.radius = 32'h0001_0000;
			send(it);
		end
		send(make_load(6'd63));
		wait_idle();
		write_reg(REG_POINT_COUNT, 32'd3);
		write_reg(REG_AFFINE_M00, 32'h8000_0000);
		write_reg(REG_AFFINE_M01, 32'h7fff_ffff);
		write_reg(REG_AFFINE_M10, 32'hffff_ffff);
		write_reg(REG_AFFINE_M11, 32'h0);
		write_reg(REG_OFFSET_X, 32'h7fff_ffff);
		write_reg(REG_OFFSET_Y, 32'h8000_0000);
		write_reg(REG_UNUSED, 32'hdead_beef);
		cfg_valid <= 1'b0;
		send(make_query(16'sh7fff, 16'sh7fff));
		send(make_query(16'sh8000, 16'sh8000));
		send(make_query(16'sd0, 16'sd0));
		send(make_query(16'sd1, 16'shffff));
		wait_idle();
		write_reg(REG_AFFINE_M00, 32'sd65536);
		write_reg(REG_AFFINE_M01, 32'd0);
		write_reg(REG_AFFINE_M10, 32'd0);
		write_reg(REG_AFFINE_M11, 32'sd65536);
		write_reg(REG_OFFSET_X, 32'd0);
		write_reg(REG_OFFSET_Y, 32'd0);
		cfg_valid <= 1'b0;
		send(make_query(16'sd5, -16'sd7));
		send(make_query(16'sh7fff, 16'sh8000));

		// fill every slot so any point count reads only written entries
		for (int i = 0; i < TABLE_DEPTH; i++)
			send(make_load(6'(i)));
		wait_idle();
		write_reg(REG_POINT_COUNT, 32'd127);
		cfg_valid <= 1'b0;
		send(make_query(16'sh7fff, 16'sh7fff));
		send(make_query(16'sh8000, 16'sh8000));
		send(make_query(16'sd3, 16'sd4));

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 88 : 0;
			recv_idle_pct = (mode == 0) ? 88 : (mode == 1) ? 12 : 0;
			for (int ph = 0; ph < 3; ph++) begin
				wait_idle();
				random_settings(ph == 2);
				if (mode == 2 && ph == 0)
					hold_off = 600;
				for (int k = 0; k < 110; k++) begin
					if ($urandom_range(99) < 30)
						send(make_load(6'($urandom())));
					else
						send(make_query(pick16(), pick16()));
				end
			end
		end

		wait_idle();
		if (sb.pending_warps.size() != 0)
			sb.report("results still outstanding at the end");
		$display("covered %0d table loads and %0d warp queries, %0d register writes",
			sb.loads, sb.queries, cfg_writes);
		$display("%0d results matched, %0d mismatches", sb.matched, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/rbfw_pkg.sv
hw/rtl/rbfw_sqrt.sv
hw/rtl/rbfw_term.sv
hw/rtl/rbf_warp_point_evaluator_unit.sv
bench/rbf_warp_point_evaluator_unit_tb.sv
